@@ hw/rtl/svf_pkg.sv @@
// Shared types and constants for the state variable filter.
// Used by svf_ctrl, svf_dp and state_variable_filter; no dependencies.
`timescale 1ns / 1ps

package svf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 15;
    localparam int QREC_W   = 17;
    localparam int MODE_W   = 2;
    localparam int CIDX_W   = 2;
    // shared multiplier: 18-bit signed by 16-bit signed
    localparam int MUL_A_W  = QREC_W + 1;
    localparam int PROD_W   = MUL_A_W + SAMPLE_W;

    localparam logic [QREC_W-1:0] QREC_RESET = QREC_W'(65536);

    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BAND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HIGH = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_Q_RECIP = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MODE    = 2'd1;

    // rounding offset for the Q1.15 products
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(16384);

    typedef struct packed {
        logic load;      // capture input item
        logic mul_damp;  // q_reciprocal * band_state
        logic mul_high;  // form high, F * high
        logic mul_band;  // form band, F * band
        logic commit;    // form low, update states, load output register
    } t_cmd;

endpackage

@@ hw/rtl/state_variable_filter.sv @@
// State variable filter: a captured input item passes through the damping
// multiply, two coefficient multiplies and a final sum. The single shared
// multiplier is used by three dependent products in turn, so no new item is
// taken until the last one is committed. A finished item waits in the output
// register while the next one is taken. Synchronous active-low reset clears
// both filter states, sets q_reciprocal to 1.0 and the mode to low-pass.
`timescale 1ns / 1ps

module state_variable_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [svf_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic        [svf_pkg::COEF_W-1:0]   i_freq_coef,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [svf_pkg::SAMPLE_W-1:0] o_filter_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [svf_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic        [svf_pkg::QREC_W-1:0]   i_cfg_data
);

    svf_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    svf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    svf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_sample_in  (i_sample_in),
        .i_freq_coef  (i_freq_coef),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_filter_out (o_filter_out)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.mul_damp, w_cmd.mul_high, w_cmd.mul_band, w_cmd.commit}))
        else $error("more than one datapath command at once");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> w_cmd.mul_damp && o_in_stall)
        else $error("accepted item did not start the damping multiply");

    a_damp_to_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul_damp |=> w_cmd.mul_high)
        else $error("high-pass step did not follow damping multiply");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out_valid)
        else $error("committed item not presented at output");

endmodule

@@ hw/rtl/svf_ctrl.sv @@
// Sequencer for the state variable filter: steps one item through the
// shared multiplier and owns both handshakes. Depends on svf_pkg.
`timescale 1ns / 1ps

module svf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output svf_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAMP,
        S_HIGH,
        S_BAND,
        S_LOW
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_damp = (r_state == S_DAMP);
        o_cmd.mul_high = (r_state == S_HIGH);
        o_cmd.mul_band = (r_state == S_BAND);
        o_cmd.commit   = (r_state == S_LOW) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid)
                        r_state <= S_DAMP;
                end
                S_DAMP: r_state <= S_HIGH;
                S_HIGH: r_state <= S_BAND;
                S_BAND: r_state <= S_LOW;
                S_LOW: begin
                    // hold here until the output register can take the item
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/svf_dp.sv @@
// Datapath for the state variable filter: config registers, filter states,
// one shared signed multiplier and the output register. Depends on svf_pkg.
`timescale 1ns / 1ps

module svf_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  svf_pkg::t_cmd                          i_cmd,
    input  logic signed [svf_pkg::SAMPLE_W-1:0]    i_sample_in,
    input  logic        [svf_pkg::COEF_W-1:0]      i_freq_coef,
    input  logic                                   i_cfg_we,
    input  logic        [svf_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic        [svf_pkg::QREC_W-1:0]      i_cfg_data,
    output logic signed [svf_pkg::SAMPLE_W-1:0]    o_filter_out
);

    logic        [svf_pkg::QREC_W-1:0]   r_q_recip;
    logic        [svf_pkg::MODE_W-1:0]   r_mode;
    logic signed [svf_pkg::SAMPLE_W-1:0] r_low_state;
    logic signed [svf_pkg::SAMPLE_W-1:0] r_band_state;
    logic signed [svf_pkg::SAMPLE_W-1:0] r_x;
    logic        [svf_pkg::COEF_W-1:0]   r_f;
    logic signed [svf_pkg::SAMPLE_W-1:0] r_high;
    logic signed [svf_pkg::SAMPLE_W-1:0] r_band;
    logic signed [svf_pkg::PROD_W-1:0]   r_prod;
    logic signed [svf_pkg::SAMPLE_W-1:0] r_out;

    logic signed [svf_pkg::MUL_A_W-1:0]  w_mul_a;
    logic signed [svf_pkg::SAMPLE_W-1:0] w_mul_b;
    logic signed [svf_pkg::PROD_W-1:0]   w_rnd_sum;
    logic signed [svf_pkg::SAMPLE_W-1:0] w_rnd;
    logic signed [svf_pkg::SAMPLE_W-1:0] n_high;
    logic signed [svf_pkg::SAMPLE_W-1:0] n_band;
    logic signed [svf_pkg::SAMPLE_W-1:0] n_low;
    logic signed [svf_pkg::SAMPLE_W-1:0] n_out;

    // floor(prod / 65536) wrapped to 16 bits is prod[31:16]
    assign n_high    = r_x - r_low_state - r_prod[31:16];
    // round(prod / 32768), halves toward plus infinity
    assign w_rnd_sum = r_prod + svf_pkg::RND_HALF;
    assign w_rnd     = w_rnd_sum[30:15];
    assign n_band    = w_rnd + r_band_state;
    assign n_low     = w_rnd + r_low_state;

    always_comb begin
        if (i_cmd.mul_damp) begin
            w_mul_a = $signed({1'b0, r_q_recip});
            w_mul_b = r_band_state;
        end else begin
            w_mul_a = $signed({{(svf_pkg::MUL_A_W - svf_pkg::COEF_W){1'b0}}, r_f});
            w_mul_b = i_cmd.mul_band ? n_band : n_high;
        end
    end

    always_comb begin
        case (r_mode)
            svf_pkg::MODE_HIGH: n_out = r_high;
            svf_pkg::MODE_BAND: n_out = r_band;
            default:            n_out = n_low;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_recip    <= svf_pkg::QREC_RESET;
            r_mode       <= svf_pkg::MODE_LOW;
            r_low_state  <= '0;
            r_band_state <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    svf_pkg::CFG_Q_RECIP: r_q_recip <= i_cfg_data;
                    svf_pkg::CFG_MODE:    r_mode    <= i_cfg_data[svf_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_band_state <= r_band;
                r_low_state  <= n_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample_in;
            r_f <= i_freq_coef;
        end
        if (i_cmd.mul_damp || i_cmd.mul_high || i_cmd.mul_band)
            r_prod <= w_mul_a * w_mul_b;
        if (i_cmd.mul_high)
            r_high <= n_high;
        if (i_cmd.mul_band)
            r_band <= n_band;
        if (i_cmd.commit)
            r_out <= n_out;
    end

    assign o_filter_out = r_out;

endmodule
